>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. Define ASSERT_OFF to remove them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: always");

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/rk4dpo_pkg.sv
// ---------------------------------------------------------------------------
// rk4dpo_pkg
// Word format, constants and saturating helpers of the RK4 oscillator core.
// ---------------------------------------------------------------------------
package rk4dpo_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 20;
    localparam int PROD_W = 2 * WORD_W;

    localparam logic signed [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic signed [WORD_W-1:0] ONE_FX = WORD_W'(1) <<< FRAC_W;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

    // Division by six: q = (m * ceil(2^34 / 6)) >> 34, exact for m < 2^32.
    localparam int DIV6_SHIFT = 34;
    localparam logic [WORD_W-1:0] DIV6_RECIP = 32'hAAAA_AAAB;

    localparam logic [2:0] EXP_MAX = 3'd4;

    localparam logic [30:0] K_RESET = 31'd52428800;
    localparam logic [30:0] G_RESET = 31'd104858;
    localparam logic [20:0] H_RESET = 21'd10486;
    localparam logic [2:0]  E_RESET = 3'd1;

    typedef enum logic [1:0] {
        CFG_K_OVER_M     = 2'd0,
        CFG_GAMMA_OVER_M = 2'd1,
        CFG_STEP_SIZE    = 2'd2,
        CFG_EXPONENT     = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic                     sat;
    } t_sat_word;

    function automatic logic [WORD_W-1:0] magnitude(input logic signed [WORD_W-1:0] a);
        return a[WORD_W-1] ? WORD_W'(-a) : WORD_W'(a);
    endfunction

    // Saturating a + b or a - b.
    function automatic t_sat_word sat_addsub(input logic signed [WORD_W-1:0] a,
                                             input logic signed [WORD_W-1:0] b,
                                             input logic                     sub);
        logic signed [WORD_W:0] s;
        t_sat_word              r;
        s = sub ? ({a[WORD_W-1], a} - {b[WORD_W-1], b})
                : ({a[WORD_W-1], a} + {b[WORD_W-1], b});
        r.sat = s[WORD_W] != s[WORD_W-1];
        if (r.sat) begin
            r.value = s[WORD_W] ? WMIN : WMAX;
        end else begin
            r.value = s[WORD_W-1:0];
        end
        return r;
    endfunction

    // Halving truncated toward zero.
    function automatic logic signed [WORD_W-1:0] half_tz(input logic signed [WORD_W-1:0] a);
        logic signed [WORD_W:0] t;
        t = {a[WORD_W-1], a} + (WORD_W+1)'(a[WORD_W-1]);
        return t[WORD_W:1];
    endfunction

endpackage

>>> rtl/core/rk4_damped_power_oscillator.sv
// ---------------------------------------------------------------------------
// rk4_damped_power_oscillator
// Damped power-law oscillator advanced by one fixed-point RK4 step per advance item.
// ---------------------------------------------------------------------------
// Usage:
// Input transactions arrive on the s_axis channel. tuser[0] selects the
// operation: 0 advances position and velocity by one RK4 step, 1 loads them
// from tdata. Every input transaction yields exactly one output transaction
// on m_axis carrying the new position and velocity and a saturation flag.
// Configuration writes (k_over_m, gamma_over_m, step_size, exponent) go over
// the cfg channel, which is ready out of reset; write only while idle.
// A load passes through the done state to the output register. An advance makes
// four derivative evaluations, each raising the position to the clamped exponent
// n (0..4), the first three also forming the next evaluation point, all of them
// through the single shared 32x32 multiplier (multiply, then round and
// saturate) and saturating adder, followed by the divide by six and the update.
// s_axis_tready is high whenever the sequencer is idle out of reset, also while
// a result waits in the output register; a stalled receiver holds the finished
// result and the next item then waits at the end of its computation.
// After reset the state is zero, the configuration holds its defaults and no
// output is pending.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rk4_damped_power_oscillator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] load_position, [63:32] load_velocity
    input  logic [0:0]  s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] position, [63:32] velocity
    output logic [0:0]  m_axis_tuser,   // [0] saturated
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int W = rk4dpo_pkg::WORD_W;

    typedef enum logic [4:0] {
        S_IDLE, S_A_MUL, S_A_RND, S_P_MUL, S_P_RND, S_K_MUL, S_K_RND, S_NEG,
        S_G_MUL, S_G_RND, S_ACC, S_B_MUL, S_B_RND, S_DBL_A, S_SUM_A, S_DBL_B,
        S_SUM_B, S_NX, S_NV, S_DIV_X, S_DIVX_RND, S_UPD_X, S_DIV_V, S_DIVV_RND,
        S_UPD_V, S_DONE
    } t_state;

    t_state r_state;

    logic [30:0] r_k_over_m;
    logic [30:0] r_gamma_over_m;
    logic [20:0] r_step_size;
    logic [2:0]  r_exponent;

    logic signed [W-1:0] r_x, r_v, r_xi, r_vi, r_p, r_t, r_acc, r_a, r_b, r_sx, r_sv;
    logic [1:0]  r_k;
    logic [2:0]  r_n;
    logic        r_sat;

    logic [rk4dpo_pkg::PROD_W-1:0] r_prod;
    logic                          r_pneg;

    logic [W-1:0] r_out_pos, r_out_vel;
    logic         r_out_sat, r_out_valid;

    logic [2:0] exp_lim;
    logic       in_acc;
    assign exp_lim = (r_exponent > rk4dpo_pkg::EXP_MAX) ? rk4dpo_pkg::EXP_MAX : r_exponent;
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign o_cfg_ready   = i_rst_n;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_vel, r_out_pos};
    assign m_axis_tuser  = r_out_sat;

    // The finished result moves on once the output register is free or being emptied.
    logic out_load;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    // Shared multiplier operands (magnitudes) and product sign.
    logic [W-1:0] mul_a, mul_b;
    logic         mul_neg;

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        unique case (r_state)
            S_A_MUL: begin
                mul_a   = W'(r_step_size);
                mul_b   = rk4dpo_pkg::magnitude(r_vi);
                mul_neg = r_vi[W-1];
            end
            S_P_MUL: begin
                mul_a   = rk4dpo_pkg::magnitude(r_p);
                mul_b   = rk4dpo_pkg::magnitude(r_xi);
                mul_neg = r_p[W-1] ^ r_xi[W-1];
            end
            S_K_MUL: begin
                mul_a   = W'(r_k_over_m);
                mul_b   = rk4dpo_pkg::magnitude(r_p);
                mul_neg = r_p[W-1];
            end
            S_G_MUL: begin
                mul_a   = W'(r_gamma_over_m);
                mul_b   = rk4dpo_pkg::magnitude(r_vi);
                mul_neg = r_vi[W-1];
            end
            S_B_MUL: begin
                mul_a   = W'(r_step_size);
                mul_b   = rk4dpo_pkg::magnitude(r_acc);
                mul_neg = r_acc[W-1];
            end
            S_DIV_X: begin
                mul_a   = rk4dpo_pkg::magnitude(r_sx);
                mul_b   = rk4dpo_pkg::DIV6_RECIP;
                mul_neg = r_sx[W-1];
            end
            S_DIV_V: begin
                mul_a   = rk4dpo_pkg::magnitude(r_sv);
                mul_b   = rk4dpo_pkg::DIV6_RECIP;
                mul_neg = r_sv[W-1];
            end
            default: begin
                mul_a   = '0;
                mul_b   = '0;
                mul_neg = 1'b0;
            end
        endcase
    end

    // Round to nearest (ties away from zero) and saturate the registered product.
    logic [rk4dpo_pkg::PROD_W-1:0]        rnd_sum;
    logic [rk4dpo_pkg::PROD_W-rk4dpo_pkg::FRAC_W-1:0] rnd_mag;
    logic [W-1:0]                         rnd_limit;
    logic                                 rnd_sat;
    logic signed [W-1:0]                  rnd_val;
    logic [W-1:0]                         div_q;
    logic signed [W-1:0]                  div_val;

    always_comb begin
        rnd_sum   = r_prod + rk4dpo_pkg::ROUND_HALF;
        rnd_mag   = rnd_sum[rk4dpo_pkg::PROD_W-1:rk4dpo_pkg::FRAC_W];
        rnd_limit = r_pneg ? W'(rk4dpo_pkg::WMIN) : W'(rk4dpo_pkg::WMAX);
        rnd_sat   = rnd_mag > (rk4dpo_pkg::PROD_W-rk4dpo_pkg::FRAC_W)'(rnd_limit);
        if (rnd_sat) begin
            rnd_val = r_pneg ? rk4dpo_pkg::WMIN : rk4dpo_pkg::WMAX;
        end else if (r_pneg) begin
            rnd_val = -$signed(rnd_mag[W-1:0]);
        end else begin
            rnd_val = $signed(rnd_mag[W-1:0]);
        end
        div_q   = W'(r_prod[rk4dpo_pkg::PROD_W-1:rk4dpo_pkg::DIV6_SHIFT]);
        div_val = r_pneg ? -$signed(div_q) : $signed(div_q);
    end

    // Shared saturating adder.
    logic signed [W-1:0] add_a, add_b;
    logic                add_sub;
    rk4dpo_pkg::t_sat_word add_res;

    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (r_state)
            S_NEG: begin
                add_a   = '0;
                add_b   = r_t;
                add_sub = 1'b1;
            end
            S_ACC: begin
                add_a   = r_t;
                add_b   = r_b;
                add_sub = 1'b1;
            end
            S_DBL_A: begin
                add_a = r_a;
                add_b = r_a;
            end
            S_SUM_A: begin
                add_a = r_sx;
                add_b = r_t;
            end
            S_DBL_B: begin
                add_a = r_b;
                add_b = r_b;
            end
            S_SUM_B: begin
                add_a = r_sv;
                add_b = r_t;
            end
            S_NX: begin
                add_a = r_x;
                add_b = (r_k == 2'd2) ? r_a : rk4dpo_pkg::half_tz(r_a);
            end
            S_NV: begin
                add_a = r_v;
                add_b = (r_k == 2'd2) ? r_b : rk4dpo_pkg::half_tz(r_b);
            end
            S_UPD_X: begin
                add_a = r_x;
                add_b = r_t;
            end
            S_UPD_V: begin
                add_a = r_v;
                add_b = r_t;
            end
            default: begin
                add_a   = '0;
                add_b   = '0;
                add_sub = 1'b0;
            end
        endcase
        add_res = rk4dpo_pkg::sat_addsub(add_a, add_b, add_sub);
    end

    // Middle stages weigh their k-values twice.
    logic dbl_stage;
    assign dbl_stage = (r_k == 2'd1) || (r_k == 2'd2);

    always_ff @(posedge i_clk) begin
        // Multiplier output register, loaded every cycle.
        r_prod <= mul_a * mul_b;
        r_pneg <= mul_neg;

        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_k_over_m     <= rk4dpo_pkg::K_RESET;
            r_gamma_over_m <= rk4dpo_pkg::G_RESET;
            r_step_size    <= rk4dpo_pkg::H_RESET;
            r_exponent     <= rk4dpo_pkg::E_RESET;
            r_x            <= '0;
            r_v            <= '0;
            r_k            <= '0;
            r_n            <= '0;
            r_sat          <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (rk4dpo_pkg::t_cfg_index'(i_cfg_index))
                    rk4dpo_pkg::CFG_K_OVER_M:     r_k_over_m     <= i_cfg_data[30:0];
                    rk4dpo_pkg::CFG_GAMMA_OVER_M: r_gamma_over_m <= i_cfg_data[30:0];
                    rk4dpo_pkg::CFG_STEP_SIZE:    r_step_size    <= i_cfg_data[20:0];
                    rk4dpo_pkg::CFG_EXPONENT:     r_exponent     <= i_cfg_data[2:0];
                endcase
            end

            if (r_out_valid && m_axis_tready && !out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_sat <= 1'b0;
                        if (s_axis_tuser[0]) begin
                            r_x     <= s_axis_tdata[31:0];
                            r_v     <= s_axis_tdata[63:32];
                            r_state <= S_DONE;
                        end else begin
                            r_xi    <= r_x;
                            r_vi    <= r_v;
                            r_k     <= '0;
                            r_state <= S_A_MUL;
                        end
                    end
                end
                S_A_MUL: r_state <= S_A_RND;
                S_A_RND: begin
                    r_a   <= rnd_val;
                    r_sat <= r_sat | rnd_sat;
                    r_p   <= rk4dpo_pkg::ONE_FX;
                    r_n   <= '0;
                    r_state <= (exp_lim == '0) ? S_K_MUL : S_P_MUL;
                end
                S_P_MUL: r_state <= S_P_RND;
                S_P_RND: begin
                    r_p   <= rnd_val;
                    r_sat <= r_sat | rnd_sat;
                    r_n   <= r_n + 3'd1;
                    r_state <= ((r_n + 3'd1) == exp_lim) ? S_K_MUL : S_P_MUL;
                end
                S_K_MUL: r_state <= S_K_RND;
                S_K_RND: begin
                    r_t     <= rnd_val;
                    r_sat   <= r_sat | rnd_sat;
                    r_state <= S_NEG;
                end
                S_NEG: begin
                    r_t     <= add_res.value;
                    r_sat   <= r_sat | add_res.sat;
                    r_state <= S_G_MUL;
                end
                S_G_MUL: r_state <= S_G_RND;
                S_G_RND: begin
                    r_b     <= rnd_val;
                    r_sat   <= r_sat | rnd_sat;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= add_res.value;
                    r_sat   <= r_sat | add_res.sat;
                    r_state <= S_B_MUL;
                end
                S_B_MUL: r_state <= S_B_RND;
                S_B_RND: begin
                    r_b     <= rnd_val;
                    r_sat   <= r_sat | rnd_sat;
                    r_state <= S_DBL_A;
                end
                S_DBL_A: begin
                    if (dbl_stage) begin
                        r_t   <= add_res.value;
                        r_sat <= r_sat | add_res.sat;
                    end else begin
                        r_t <= r_a;
                    end
                    r_state <= S_SUM_A;
                end
                S_SUM_A: begin
                    if (r_k == 2'd0) begin
                        r_sx <= r_t;
                    end else begin
                        r_sx  <= add_res.value;
                        r_sat <= r_sat | add_res.sat;
                    end
                    r_state <= S_DBL_B;
                end
                S_DBL_B: begin
                    if (dbl_stage) begin
                        r_t   <= add_res.value;
                        r_sat <= r_sat | add_res.sat;
                    end else begin
                        r_t <= r_b;
                    end
                    r_state <= S_SUM_B;
                end
                S_SUM_B: begin
                    if (r_k == 2'd0) begin
                        r_sv <= r_t;
                    end else begin
                        r_sv  <= add_res.value;
                        r_sat <= r_sat | add_res.sat;
                    end
                    r_state <= (r_k == 2'd3) ? S_DIV_X : S_NX;
                end
                S_NX: begin
                    r_xi    <= add_res.value;
                    r_sat   <= r_sat | add_res.sat;
                    r_state <= S_NV;
                end
                S_NV: begin
                    r_vi    <= add_res.value;
                    r_sat   <= r_sat | add_res.sat;
                    r_k     <= r_k + 2'd1;
                    r_state <= S_A_MUL;
                end
                S_DIV_X: r_state <= S_DIVX_RND;
                S_DIVX_RND: begin
                    r_t     <= div_val;
                    r_state <= S_UPD_X;
                end
                S_UPD_X: begin
                    r_x     <= add_res.value;
                    r_sat   <= r_sat | add_res.sat;
                    r_state <= S_DIV_V;
                end
                S_DIV_V: r_state <= S_DIVV_RND;
                S_DIVV_RND: begin
                    r_t     <= div_val;
                    r_state <= S_UPD_V;
                end
                S_UPD_V: begin
                    r_v     <= add_res.value;
                    r_sat   <= r_sat | add_res.sat;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // Wait until the output register is free or being emptied.
                    if (out_load) begin
                        r_out_pos   <= r_x;
                        r_out_vel   <= r_v;
                        r_out_sat   <= r_sat;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_ALWAYS(a_pow_count, i_clk, i_rst_n, r_n <= rk4dpo_pkg::EXP_MAX)
    `ASSERT_NEXT(a_load_done, i_clk, i_rst_n, in_acc && s_axis_tuser[0], r_state == S_DONE)
    `ASSERT_IMPLIES(a_div_last, i_clk, i_rst_n, r_state == S_DIV_X, r_k == 2'd3)
    `ASSERT_NEXT(a_done_out, i_clk, i_rst_n, out_load, r_out_valid && (r_state == S_IDLE))

endmodule

>>> test/tb_rk4_damped_power_oscillator.sv
// ---------------------------------------------------------------------------
// tb_rk4_damped_power_oscillator
// Self-checking bench for the fixed-point RK4 damped power-law oscillator.
// A queue-fed driver offers load and advance transactions on s_axis while a
// bit-accurate predictor computes the state after each accepted transaction.
// A monitor compares every m_axis transaction with the oldest prediction.
// The run sweeps several register settings, with random stalls on both
// streams and one long receiver hold-off that backs up the input.
// ---------------------------------------------------------------------------
module tb_rk4_damped_power_oscillator;
    timeunit 1ns;
    timeprecision 1ps;

    import rk4dpo_pkg::*;

    localparam logic MODE_ADVANCE = 1'b0;
    localparam logic MODE_LOAD    = 1'b1;

    localparam longint W_HI = WMAX;
    localparam longint W_LO = WMIN;

    typedef struct {
        logic        mode;
        logic [31:0] load_position;
        logic [31:0] load_velocity;
    } osc_item_t;

    typedef struct {
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic               saturated;
    } osc_state_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;    // [31:0] load_position, [63:32] load_velocity
    logic [0:0]  s_axis_tuser = '0;    // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;         // [31:0] position, [63:32] velocity
    logic [0:0]  m_axis_tuser;         // [0] saturated
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    rk4_damped_power_oscillator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of the oscillator state and registers.
    longint      osc_pos = 0;
    longint      osc_vel = 0;
    logic [30:0] k_cfg = K_RESET;
    logic [30:0] g_cfg = G_RESET;
    logic [20:0] h_cfg = H_RESET;
    logic [2:0]  e_cfg = E_RESET;
    bit          sat_hit;

    osc_item_t  items_to_send[$];
    osc_state_t pending_states[$];
    osc_item_t  tx_item;
    osc_state_t exp_state;
    int         tx_gap;
    int         rx_stall;
    bit         idle_en = 1'b1;
    bit         rx_hold_req = 1'b0;
    int         mismatch_cnt = 0;

    function automatic longint clip_word(input longint a);
        if (a > W_HI) begin
            sat_hit = 1'b1;
            return W_HI;
        end
        if (a < W_LO) begin
            sat_hit = 1'b1;
            return W_LO;
        end
        return a;
    endfunction

    function automatic longint sat_add(input longint a, input longint b);
        return clip_word(a + b);
    endfunction

    function automatic longint sat_sub(input longint a, input longint b);
        return clip_word(a - b);
    endfunction

    // Exact product, magnitude rounded half away from zero, then saturated.
    function automatic longint fx_mul(input longint a, input longint b);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] prod;
        logic [127:0] lim;
        bit           neg;
        ma = (a < 0) ? 64'(-a) : 64'(a);
        mb = (b < 0) ? 64'(-b) : 64'(b);
        neg = (a < 0) != (b < 0);
        prod = {64'd0, ma} * {64'd0, mb};
        prod = (prod + 128'(ROUND_HALF)) >> FRAC_W;
        lim = neg ? 128'(W_HI) + 128'd1 : 128'(W_HI);
        if (prod > lim) begin
            sat_hit = 1'b1;
            return neg ? W_LO : W_HI;
        end
        return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function automatic longint accel_of(input longint x, input longint v);
        longint p;
        int     n;
        n = (e_cfg > EXP_MAX) ? int'(EXP_MAX) : int'(e_cfg);
        p = longint'(ONE_FX);
        for (int i = 0; i < n; i++) begin
            p = fx_mul(p, x);
        end
        return sat_sub(sat_sub(0, fx_mul(longint'(k_cfg), p)), fx_mul(longint'(g_cfg), v));
    endfunction

    // Applies one transaction to the predicted state and returns the result.
    function automatic osc_state_t rk4_predict(input osc_item_t it);
        longint     h, x, v, a1, b1, a2, b2, a3, b3, a4, b4, sx, sv;
        osc_state_t r;
        sat_hit = 1'b0;
        if (it.mode == MODE_LOAD) begin
            osc_pos = clip_word(longint'(signed'(it.load_position)));
            osc_vel = clip_word(longint'(signed'(it.load_velocity)));
        end else begin
            h = longint'(h_cfg);
            x = osc_pos;
            v = osc_vel;
            a1 = fx_mul(h, v);
            b1 = fx_mul(h, accel_of(x, v));
            a2 = fx_mul(h, sat_add(v, b1 / 2));
            b2 = fx_mul(h, accel_of(sat_add(x, a1 / 2), sat_add(v, b1 / 2)));
            a3 = fx_mul(h, sat_add(v, b2 / 2));
            b3 = fx_mul(h, accel_of(sat_add(x, a2 / 2), sat_add(v, b2 / 2)));
            a4 = fx_mul(h, sat_add(v, b3));
            b4 = fx_mul(h, accel_of(sat_add(x, a3), sat_add(v, b3)));
            sx = sat_add(sat_add(sat_add(a1, sat_add(a2, a2)), sat_add(a3, a3)), a4);
            sv = sat_add(sat_add(sat_add(b1, sat_add(b2, b2)), sat_add(b3, b3)), b4);
            osc_pos = sat_add(x, sx / 6);
            osc_vel = sat_add(v, sv / 6);
        end
        r.position  = osc_pos[31:0];
        r.velocity  = osc_vel[31:0];
        r.saturated = sat_hit;
        return r;
    endfunction

    // Mix of full-range, moderate, tiny and extreme words.
    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        int          sel;
        sel = $urandom_range(0, 5);
        case (sel)
            0, 1: w = $urandom;
            2: w = $urandom_range(0, 32'h0040_0000);
            3: begin
                case ($urandom_range(0, 3))
                    0: w = 32'h7FFF_FFFF;
                    1: w = 32'h8000_0000;
                    2: w = 32'h0000_0000;
                    default: w = ONE_FX;
                endcase
            end
            default: w = $urandom_range(0, 32'h0200_0000);
        endcase
        if ((sel == 2 || sel > 3) && $urandom_range(0, 1) == 1) begin
            w = -w;
        end
        return w;
    endfunction

    task automatic push_item(input logic mode, input logic [31:0] pos, input logic [31:0] vel);
        osc_item_t it;
        it.mode = mode;
        it.load_position = pos;
        it.load_velocity = vel;
        items_to_send.push_back(it);
    endtask

    task automatic cfg_write(input t_cfg_index idx, input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_K_OVER_M:     k_cfg = value[30:0];
            CFG_GAMMA_OVER_M: g_cfg = value[30:0];
            CFG_STEP_SIZE:    h_cfg = value[20:0];
            CFG_EXPONENT:     e_cfg = value[2:0];
        endcase
    endtask

    task automatic load_config(input logic [31:0] k, input logic [31:0] g,
                               input logic [31:0] h, input logic [31:0] e);
        cfg_write(CFG_K_OVER_M, k);
        cfg_write(CFG_GAMMA_OVER_M, g);
        cfg_write(CFG_STEP_SIZE, h);
        cfg_write(CFG_EXPONENT, e);
        @(negedge i_clk);
    endtask

    // Every transaction yields one result, so the core is idle once all have come back.
    task automatic drain();
        while (items_to_send.size() != 0 || s_axis_tvalid || pending_states.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                pending_states.push_back(rk4_predict(tx_item));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (items_to_send.size() != 0) begin
                    tx_item = items_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {tx_item.load_velocity, tx_item.load_position};
                    s_axis_tuser  <= tx_item.mode;
                    if (idle_en && $urandom_range(0, 5) == 0) begin
                        tx_gap = $urandom_range(1, 13);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_states.size() == 0) begin
                    $error("output transaction with no pending prediction");
                    mismatch_cnt++;
                end else begin
                    exp_state = pending_states.pop_front();
                    if (m_axis_tdata[31:0] !== exp_state.position) begin
                        $error("position: expected %0d, actual %0d",
                               exp_state.position, $signed(m_axis_tdata[31:0]));
                        mismatch_cnt++;
                    end
                    if (m_axis_tdata[63:32] !== exp_state.velocity) begin
                        $error("velocity: expected %0d, actual %0d",
                               exp_state.velocity, $signed(m_axis_tdata[63:32]));
                        mismatch_cnt++;
                    end
                    if (m_axis_tuser[0] !== exp_state.saturated) begin
                        $error("saturated: expected %0b, actual %0b",
                               exp_state.saturated, m_axis_tuser[0]);
                        mismatch_cnt++;
                    end
                end
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end else if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_stall = 399;
                m_axis_tready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 6) == 0) begin
                rx_stall = $urandom_range(0, 12);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        #6_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [31:0] k_val, g_val, h_val, e_val;
        int          n_items;
        int          run_len;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset defaults: advance from the zero state, then extreme loads.
        push_item(MODE_ADVANCE, 32'h0, 32'h0);
        push_item(MODE_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_item(MODE_ADVANCE, 32'h0, 32'h0);
        push_item(MODE_LOAD, 32'h8000_0000, 32'h8000_0000);
        push_item(MODE_ADVANCE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(MODE_LOAD, ONE_FX, 32'h0);
        repeat (3) push_item(MODE_ADVANCE, 32'h0, 32'h0);
        drain();

        // Power zero gives a constant force, also at zero position.
        load_config(32'h7FFF_FFFF, 32'h0, 32'd1048576, 32'd0);
        push_item(MODE_LOAD, 32'h0, 32'h0);
        repeat (2) push_item(MODE_ADVANCE, 32'h0, 32'h0);
        drain();

        // Exponent above four with a zero step leaves the state unchanged.
        load_config(K_RESET, 32'h7FFF_FFFF, 32'h0, 32'd7);
        push_item(MODE_LOAD, ONE_FX, ONE_FX);
        push_item(MODE_ADVANCE, 32'h0, 32'h0);
        drain();

        // All-ones writes exercise the register masks and the largest step.
        load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5);
        push_item(MODE_LOAD, 32'h0020_0000, 32'hFFF0_0000);
        repeat (2) push_item(MODE_ADVANCE, 32'h0, 32'h0);
        drain();

        load_config(32'h0, 32'h0, 32'd1, 32'd2);
        push_item(MODE_LOAD, 32'h8000_0000, 32'h7FFF_FFFF);
        push_item(MODE_ADVANCE, 32'h0, 32'h0);
        drain();

        load_config(K_RESET, G_RESET, H_RESET, 32'd3);
        push_item(MODE_LOAD, 32'hFFF8_0000, ONE_FX);
        repeat (2) push_item(MODE_ADVANCE, 32'h0, 32'h0);
        drain();

        load_config(K_RESET, G_RESET, H_RESET, 32'd4);
        push_item(MODE_LOAD, ONE_FX, 32'h0);
        repeat (2) push_item(MODE_ADVANCE, 32'h0, 32'h0);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            case ($urandom_range(0, 7))
                0: k_val = 32'h0;
                1: k_val = 32'h7FFF_FFFF;
                2: k_val = $urandom;
                default: k_val = $urandom_range(0, 32'd209715200);
            endcase
            case ($urandom_range(0, 5))
                0: g_val = 32'h0;
                1: g_val = $urandom;
                default: g_val = $urandom_range(0, 32'd4194304);
            endcase
            case ($urandom_range(0, 9))
                0: h_val = 32'h0;
                1: h_val = 32'd1;
                2: h_val = 32'd1048576;
                3: h_val = $urandom;
                default: h_val = $urandom_range(1, 20000);
            endcase
            e_val = $urandom_range(0, 7);
            load_config(k_val, g_val, h_val, e_val);
            idle_en = (ph < 9) ? ($urandom_range(0, 3) != 0) : 1'b0;
            if (ph == 2) begin
                idle_en = 1'b1;
                rx_hold_req = 1'b1;
            end

            // Mostly a load followed by a run of advances; some runs just continue.
            n_items = 0;
            while (n_items < 60) begin
                if ($urandom_range(0, 5) != 0) begin
                    push_item(MODE_LOAD, rand_word(), rand_word());
                    n_items++;
                end
                run_len = $urandom_range(1, 15);
                repeat (run_len) begin
                    push_item(MODE_ADVANCE, $urandom, $urandom);
                    n_items++;
                end
            end
            drain();
        end

        repeat (150) @(posedge i_clk);
        if (pending_states.size() != 0) begin
            $error("%0d predicted results never arrived", pending_states.size());
            mismatch_cnt++;
        end
        if (mismatch_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
